// File: design/tsd_pkg.sv
// shared types and constants of the tick scheduler with debounce
package tsd_pkg;

    localparam int BUTTON_DEBOUNCE_LIMIT = 2;
    localparam int TIMEOUT_WIDTH = 16;

    localparam int BTN_CNT_W = 2;
    localparam logic [BTN_CNT_W-1:0] BTN_LIMIT = BTN_CNT_W'(BUTTON_DEBOUNCE_LIMIT);

    localparam int NUM_DIV = 7;
    localparam int unsigned DIV_LIMITS [NUM_DIV] = '{3, 5, 10, 50, 100, 500, 1000};

    localparam int NUM_TO = 3;
    localparam int TO_IDX_SPLASH = 0;
    localparam int TO_IDX_PLUS = 1;
    localparam int TO_IDX_MINUS = 2;

    localparam logic [1:0] TO_SEL_NONE = 2'd0;
    localparam logic [1:0] TO_SEL_SPLASH = 2'd1;
    localparam logic [1:0] TO_SEL_PLUS = 2'd2;
    localparam logic [1:0] TO_SEL_MINUS = 2'd3;

    localparam logic [15:0] PULSE_MAX = 16'hFFFF;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [7:0] CFG_DEB_LIMIT_RESET = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_ONE_LEVEL = 2'd0,
        CFG_IN_TWO_LEVEL = 2'd1,
        CFG_IN_DEB_LIMIT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic        clock_button_level;
        logic        minus_button_level;
        logic        plus_button_level;
        logic        input_one_level;
        logic        input_two_level;
        logic [7:0]  flag_clear_mask;
        logic        pulse_clear;
        logic        event_clear;
        logic [1:0]  timeout_select;
        logic [15:0] timeout_value;
    } t_tsd_in;

    typedef struct packed {
        logic [7:0]  rate_flags;
        logic        clock_button_pressed;
        logic        minus_button_pressed;
        logic        plus_button_pressed;
        logic        input_one_active;
        logic        input_two_active;
        logic [15:0] pending_pulses;
        logic        input_two_event;
        logic [15:0] splash_left;
        logic [15:0] plus_left;
        logic [15:0] minus_left;
    } t_tsd_out;

endpackage

// File: design/tsd_in_if.sv
// tick item channel
interface tsd_in_if
    import tsd_pkg::*;
;
    logic    valid;
    logic    ready;
    t_tsd_in payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: design/tsd_out_if.sv
// result item channel
interface tsd_out_if
    import tsd_pkg::*;
;
    logic     valid;
    logic     ready;
    t_tsd_out payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: design/tick_scheduler_with_debounce.sv
// tick scheduler: prescalers, sticky rate flags, debounce, pulse count and timeouts
//
//  channel   dir   signals                          transfer when
//  i_in      in    valid, ready, payload (ticks)     valid & ready
//  o_out     out   valid, ready, payload (results)   valid & ready
//  i_cfg     in    i_cfg_we, i_cfg_idx, i_cfg_data   i_cfg_we
//
//  one tick per cycle while o_out is not stalled; the state update is a single pass of counter logic
//  the result appears in the output register the cycle after the transfer
//  i_in.ready is high while the output register is empty or being taken
//  a stall on o_out holds the result and blocks only the next tick
//  synchronous active-low reset clears all state but the result payload and sets the debounce limit to 2
module tick_scheduler_with_debounce
    import tsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tsd_in_if.sink                i_in,
    tsd_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                     r_one_level;
    logic                     r_two_level;
    logic [7:0]               r_deb_limit;

    logic [7:0]               r_flags;
    logic [BTN_CNT_W-1:0]     r_btn_cnt [3];
    logic [7:0]               r_in_cnt [2];
    logic [4:0]               r_deb;
    logic [15:0]              r_pulse;
    logic                     r_event;
    logic [TIMEOUT_WIDTH-1:0] r_to [NUM_TO];
    logic                     r_out_valid;
    t_tsd_out                 r_out;

    logic [7:0]               n_flags;
    logic [BTN_CNT_W-1:0]     n_btn_cnt [3];
    logic [7:0]               n_in_cnt [2];
    logic [4:0]               n_deb;
    logic [15:0]              n_pulse;
    logic                     n_event;
    logic [TIMEOUT_WIDTH-1:0] n_to [NUM_TO];
    t_tsd_out                 n_out;

    logic                     w_accept;
    logic [7:0]               w_fired;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_level <= 1'b0;
            r_two_level <= 1'b0;
            r_deb_limit <= CFG_DEB_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IN_ONE_LEVEL: begin
                    r_one_level <= i_cfg_data[0];
                end
                CFG_IN_TWO_LEVEL: begin
                    r_two_level <= i_cfg_data[0];
                end
                CFG_IN_DEB_LIMIT: begin
                    r_deb_limit <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // prescalers
    assign w_fired[0] = 1'b1;

    for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
        localparam int W = $clog2(DIV_LIMITS[g]);
        logic [W-1:0] r_cnt;

        assign w_fired[g+1] = (r_cnt == W'(DIV_LIMITS[g] - 1));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cnt <= '0;
            end else if (w_accept) begin
                r_cnt <= w_fired[g+1] ? '0 : r_cnt + 1'b1;
            end
        end
    end

    // returns {state, count}
    function automatic logic [8:0] f_debounce(input logic [7:0] cnt, input logic act,
                                              input logic [7:0] lim, input logic st);
        logic [8:0] res;
        res = {st, cnt};
        if (!act) begin
            res = 9'd0;
        end else if (cnt < lim) begin
            res[7:0] = cnt + 8'd1;
        end else begin
            res[8] = 1'b1;
        end
        return res;
    endfunction

    always_comb begin
        logic [8:0]               deb;
        logic [15:0]              pulse_base;
        logic                     event_base;
        logic [31:0]              load_wide;
        logic [TIMEOUT_WIDTH-1:0] load;
        logic [TIMEOUT_WIDTH-1:0] to_base [NUM_TO];
        logic [31:0]              to_wide [NUM_TO];

        deb = '0;
        n_flags = (r_flags & ~i_in.payload.flag_clear_mask) | w_fired;
        pulse_base = i_in.payload.pulse_clear ? 16'd0 : r_pulse;
        event_base = i_in.payload.event_clear ? 1'b0 : r_event;

        n_btn_cnt = r_btn_cnt;
        n_in_cnt = r_in_cnt;
        n_deb = r_deb;
        n_pulse = pulse_base;
        n_event = event_base;

        // sampling on the divide-by-three tick
        if (w_fired[1]) begin
            deb = f_debounce(8'(r_btn_cnt[0]), !i_in.payload.clock_button_level,
                             8'(BTN_LIMIT), r_deb[0]);
            n_btn_cnt[0] = BTN_CNT_W'(deb[7:0]);
            n_deb[0] = deb[8];
            deb = f_debounce(8'(r_btn_cnt[1]), !i_in.payload.minus_button_level,
                             8'(BTN_LIMIT), r_deb[1]);
            n_btn_cnt[1] = BTN_CNT_W'(deb[7:0]);
            n_deb[1] = deb[8];
            deb = f_debounce(8'(r_btn_cnt[2]), !i_in.payload.plus_button_level,
                             8'(BTN_LIMIT), r_deb[2]);
            n_btn_cnt[2] = BTN_CNT_W'(deb[7:0]);
            n_deb[2] = deb[8];
            deb = f_debounce(r_in_cnt[0], i_in.payload.input_one_level == r_one_level,
                             r_deb_limit, r_deb[3]);
            n_in_cnt[0] = deb[7:0];
            n_deb[3] = deb[8];
            deb = f_debounce(r_in_cnt[1], i_in.payload.input_two_level == r_two_level,
                             r_deb_limit, r_deb[4]);
            n_in_cnt[1] = deb[7:0];
            n_deb[4] = deb[8];

            // rising edges against the previous debounced state
            if (n_deb[3] && !r_deb[3] && pulse_base != PULSE_MAX) begin
                n_pulse = pulse_base + 16'd1;
            end
            if (n_deb[4] && !r_deb[4]) begin
                n_event = 1'b1;
            end
        end

        load_wide = 32'(i_in.payload.timeout_value);
        load = load_wide[TIMEOUT_WIDTH-1:0];
        to_base = r_to;
        case (i_in.payload.timeout_select)
            TO_SEL_SPLASH: to_base[TO_IDX_SPLASH] = load;
            TO_SEL_PLUS:   to_base[TO_IDX_PLUS] = load;
            TO_SEL_MINUS:  to_base[TO_IDX_MINUS] = load;
            default:       ;
        endcase

        for (int k = 0; k < NUM_TO; k++) begin
            if (w_fired[4] && to_base[k] != '0) begin
                n_to[k] = to_base[k] - 1'b1;
            end else begin
                n_to[k] = to_base[k];
            end
            to_wide[k] = 32'(n_to[k]);
        end

        n_out.rate_flags = n_flags;
        n_out.clock_button_pressed = n_deb[0];
        n_out.minus_button_pressed = n_deb[1];
        n_out.plus_button_pressed = n_deb[2];
        n_out.input_one_active = n_deb[3];
        n_out.input_two_active = n_deb[4];
        n_out.pending_pulses = n_pulse;
        n_out.input_two_event = n_event;
        n_out.splash_left = to_wide[TO_IDX_SPLASH][15:0];
        n_out.plus_left = to_wide[TO_IDX_PLUS][15:0];
        n_out.minus_left = to_wide[TO_IDX_MINUS][15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_btn_cnt <= '{default: '0};
            r_in_cnt <= '{default: '0};
            r_deb <= '0;
            r_pulse <= '0;
            r_event <= 1'b0;
            r_to <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_flags <= n_flags;
                r_btn_cnt <= n_btn_cnt;
                r_in_cnt <= n_in_cnt;
                r_deb <= n_deb;
                r_pulse <= n_pulse;
                r_event <= n_event;
                r_to <= n_to;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("transfer in without a result");

    a_fast_flag_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_flags[0] && r_out.rate_flags[0])
        else $error("1 ms flag not set after a tick");

    a_pulse_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_in.payload.pulse_clear |=> r_pulse >= $past(r_pulse))
        else $error("pulse count dropped without a clear");

    a_button_rise_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_deb[0]) |-> r_btn_cnt[0] == BTN_LIMIT)
        else $error("button asserted before its count reached the limit");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_to[TO_IDX_SPLASH]) && $stable(r_pulse) && $stable(r_flags))
        else $error("state moved without a transfer");

endmodule

// File: tb/sv/tb_tick_scheduler_with_debounce.sv
// self-checking testbench for the tick scheduler with debounce
module tb_tick_scheduler_with_debounce;
    import tsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int IDLE_PCT = 18;
    localparam int MAX_REPORTS = 200;
    // rising edges of input one at one edge per six ticks
    localparam int PULSE_TICKS = 42;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tsd_in_if tick_if ();
    tsd_out_if result_if ();

    tick_scheduler_with_debounce dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_if),
        .o_out      (result_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predicted block state
    int unsigned div_count [NUM_DIV] = '{default: 0};
    logic [7:0] rate_sticky = '0;
    logic [7:0] btn_count [3] = '{default: '0};
    logic [7:0] in_count [2] = '{default: '0};
    logic [4:0] deb_state = '0;
    logic [1:0] prev_in_state = '0;
    logic [15:0] pulse_count = '0;
    logic event_flag = 1'b0;
    logic [15:0] timeout_left [NUM_TO] = '{default: '0};
    logic level_one = 1'b0;
    logic level_two = 1'b0;
    logic [7:0] deb_limit = CFG_DEB_LIMIT_RESET;

    t_tsd_out predicted_status_q [$];
    int error_count = 0;
    bit no_idle = 1'b0;

    // pin pattern for random ticks: bit0 clock, bit1 minus, bit2 plus, bit3 in one, bit4 in two
    logic [4:0] held_pins = 5'h1F;
    int flip_pct = 5;
    int glitch_pct = 4;

    function automatic logic [8:0] debounce_step(input logic [7:0] cnt, input logic active,
                                                 input logic [7:0] lim, input logic state);
        if (active) begin
            if (cnt < lim) begin
                cnt = cnt + 8'd1;
            end else begin
                state = 1'b1;
            end
        end else begin
            cnt = '0;
            state = 1'b0;
        end
        return {state, cnt};
    endfunction

    function automatic t_tsd_out advance_tick(input t_tsd_in t);
        logic [7:0] fired;
        logic [2:0] btn_pins;
        logic [8:0] r;
        logic [4:0] n;
        t_tsd_out o;
        fired = 8'h01;
        n = deb_state;
        btn_pins = {t.plus_button_level, t.minus_button_level, t.clock_button_level};
        rate_sticky = rate_sticky & ~t.flag_clear_mask;
        if (t.pulse_clear) begin
            pulse_count = '0;
        end
        if (t.event_clear) begin
            event_flag = 1'b0;
        end
        case (t.timeout_select)
            TO_SEL_SPLASH: timeout_left[TO_IDX_SPLASH] = t.timeout_value;
            TO_SEL_PLUS: timeout_left[TO_IDX_PLUS] = t.timeout_value;
            TO_SEL_MINUS: timeout_left[TO_IDX_MINUS] = t.timeout_value;
            default: ;
        endcase
        for (int i = 0; i < NUM_DIV; i++) begin
            div_count[i] = div_count[i] + 1;
            if (div_count[i] >= DIV_LIMITS[i]) begin
                div_count[i] = 0;
                fired[i+1] = 1'b1;
            end
        end
        rate_sticky = rate_sticky | fired;
        if (fired[1]) begin
            for (int i = 0; i < 3; i++) begin
                r = debounce_step(btn_count[i], ~btn_pins[i], 8'(BUTTON_DEBOUNCE_LIMIT),
                                  deb_state[i]);
                btn_count[i] = r[7:0];
                n[i] = r[8];
            end
            r = debounce_step(in_count[0], t.input_one_level == level_one, deb_limit,
                              deb_state[3]);
            in_count[0] = r[7:0];
            n[3] = r[8];
            if (n[3] && !prev_in_state[0] && pulse_count != PULSE_MAX) begin
                pulse_count = pulse_count + 16'd1;
            end
            r = debounce_step(in_count[1], t.input_two_level == level_two, deb_limit,
                              deb_state[4]);
            in_count[1] = r[7:0];
            n[4] = r[8];
            if (n[4] && !prev_in_state[1]) begin
                event_flag = 1'b1;
            end
            prev_in_state = n[4:3];
            deb_state = n;
        end
        if (fired[4]) begin
            for (int i = 0; i < NUM_TO; i++) begin
                if (timeout_left[i] != '0) begin
                    timeout_left[i] = timeout_left[i] - 16'd1;
                end
            end
        end
        o.rate_flags = rate_sticky;
        o.clock_button_pressed = deb_state[0];
        o.minus_button_pressed = deb_state[1];
        o.plus_button_pressed = deb_state[2];
        o.input_one_active = deb_state[3];
        o.input_two_active = deb_state[4];
        o.pending_pulses = pulse_count;
        o.input_two_event = event_flag;
        o.splash_left = timeout_left[TO_IDX_SPLASH];
        o.plus_left = timeout_left[TO_IDX_PLUS];
        o.minus_left = timeout_left[TO_IDX_MINUS];
        return o;
    endfunction

    function automatic t_tsd_in tick_of(input logic [4:0] pins, input logic [7:0] mask,
                                        input logic pclr, input logic eclr,
                                        input logic [1:0] sel, input logic [15:0] val);
        t_tsd_in t;
        t.clock_button_level = pins[0];
        t.minus_button_level = pins[1];
        t.plus_button_level = pins[2];
        t.input_one_level = pins[3];
        t.input_two_level = pins[4];
        t.flag_clear_mask = mask;
        t.pulse_clear = pclr;
        t.event_clear = eclr;
        t.timeout_select = sel;
        t.timeout_value = val;
        return t;
    endfunction

    function automatic t_tsd_in random_tick();
        logic [4:0] pins;
        logic [7:0] mask;
        logic [1:0] sel;
        logic [15:0] val;
        int r;
        for (int i = 0; i < 5; i++) begin
            if ($urandom_range(99) < flip_pct) begin
                held_pins[i] = ~held_pins[i];
            end
        end
        pins = held_pins;
        if ($urandom_range(99) < glitch_pct) begin
            pins[$urandom_range(4)] ^= 1'b1;
        end
        mask = ($urandom_range(99) < 25) ? 8'($urandom_range(255)) : 8'h00;
        sel = ($urandom_range(99) < 20) ? 2'($urandom_range(3)) : TO_SEL_NONE;
        r = $urandom_range(99);
        if (r < 70) begin
            val = 16'($urandom_range(30));
        end else if (r < 85) begin
            val = 16'($urandom_range(65535));
        end else begin
            case ($urandom_range(3))
                0: val = 16'h0000;
                1: val = 16'h0001;
                2: val = 16'hFFFE;
                default: val = 16'hFFFF;
            endcase
        end
        return tick_of(pins, mask, $urandom_range(99) < 4, $urandom_range(99) < 8, sel, val);
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            error_count++;
            // further mismatches still count
            if (error_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        end
    endfunction

    task automatic check_result(input t_tsd_out got);
        t_tsd_out want;
        if (predicted_status_q.size() == 0) begin
            error_count++;
            $display("%0t: result transfer with no tick waiting, expected none, actual 0x%0h",
                     $time, got);
        end else begin
            want = predicted_status_q.pop_front();
            compare_field("rate_flags", want.rate_flags, got.rate_flags);
            compare_field("clock_button_pressed", want.clock_button_pressed,
                          got.clock_button_pressed);
            compare_field("minus_button_pressed", want.minus_button_pressed,
                          got.minus_button_pressed);
            compare_field("plus_button_pressed", want.plus_button_pressed,
                          got.plus_button_pressed);
            compare_field("input_one_active", want.input_one_active, got.input_one_active);
            compare_field("input_two_active", want.input_two_active, got.input_two_active);
            compare_field("pending_pulses", want.pending_pulses, got.pending_pulses);
            compare_field("input_two_event", want.input_two_event, got.input_two_event);
            compare_field("splash_left", want.splash_left, got.splash_left);
            compare_field("plus_left", want.plus_left, got.plus_left);
            compare_field("minus_left", want.minus_left, got.minus_left);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            check_result(result_if.payload);
        end
    end

    always @(negedge i_clk) begin
        result_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_tick(input t_tsd_in t);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            tick_if.valid = 1'b0;
            @(negedge i_clk);
        end
        tick_if.valid = 1'b1;
        tick_if.payload = t;
        do @(posedge i_clk); while (tick_if.ready !== 1'b1);
        predicted_status_q.push_back(advance_tick(t));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        tick_if.valid = 1'b0;
        while (predicted_status_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            CFG_IN_ONE_LEVEL: level_one = data[0];
            CFG_IN_TWO_LEVEL: level_two = data[0];
            CFG_IN_DEB_LIMIT: deb_limit = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_tick(random_tick());
    endtask

    task automatic test_directed_extremes();
        // all pins low: buttons pressed and both inputs active at reset levels
        send_tick(tick_of(5'h00, 8'h00, 1'b0, 1'b0, TO_SEL_SPLASH, 16'hFFFF));
        send_tick(tick_of(5'h00, 8'h00, 1'b0, 1'b0, TO_SEL_PLUS, 16'h0001));
        send_tick(tick_of(5'h00, 8'h00, 1'b0, 1'b0, TO_SEL_MINUS, 16'h0000));
        send_tick(tick_of(5'h00, 8'h00, 1'b0, 1'b0, TO_SEL_NONE, 16'hFFFF));
        repeat (8) send_tick(tick_of(5'h00, 8'h00, 1'b0, 1'b0, TO_SEL_NONE, 16'h0000));
        send_tick(tick_of(5'h1F, 8'hFF, 1'b1, 1'b1, TO_SEL_SPLASH, 16'h0002));
        send_tick(tick_of(5'h1F, 8'h55, 1'b0, 1'b0, TO_SEL_NONE, 16'h5555));
        repeat (5) send_tick(tick_of(5'h1F, 8'h00, 1'b0, 1'b0, TO_SEL_NONE, 16'hAAAA));
        send_tick(tick_of(5'h1F, 8'hAA, 1'b0, 1'b0, TO_SEL_NONE, 16'h0000));
        send_tick(tick_of(5'h1F, 8'hFF, 1'b1, 1'b1, TO_SEL_MINUS, 16'hFFFF));
        drain_results();
    endtask

    task automatic test_default_random();
        run_random(180);
        drain_results();
    endtask

    task automatic test_inverted_levels_zero_limit();
        write_cfg(CFG_IN_ONE_LEVEL, 8'hFF);
        write_cfg(CFG_IN_TWO_LEVEL, 8'h01);
        write_cfg(CFG_IN_DEB_LIMIT, 8'h00);
        run_random(200);
        drain_results();
    endtask

    task automatic test_limit_lowered_mid_count();
        write_cfg(CFG_IN_DEB_LIMIT, 8'hFF);
        flip_pct = 0;
        glitch_pct = 0;
        held_pins = {level_two, level_one, 3'b000};
        run_random(150);
        drain_results();
        write_cfg(CFG_IN_DEB_LIMIT, 8'h01);
        run_random(20);
        flip_pct = 5;
        glitch_pct = 4;
        run_random(180);
        drain_results();
    endtask

    task automatic test_spare_index_and_no_idle();
        // unused index must leave the limit of one untouched
        write_cfg(CFG_IDX_SPARE, 8'h00);
        write_cfg(CFG_IN_ONE_LEVEL, 8'h00);
        write_cfg(CFG_IN_TWO_LEVEL, 8'hFE);
        no_idle = 1'b1;
        run_random(120);
        no_idle = 1'b0;
        drain_results();
        write_cfg(CFG_IDX_SPARE, 8'hFF);
        run_random(10);
        drain_results();
        write_cfg(CFG_IN_DEB_LIMIT, 8'h03);
        run_random(120);
        drain_results();
    endtask

    task automatic test_pulse_edges();
        logic in_one;
        write_cfg(CFG_IN_ONE_LEVEL, 8'h01);
        write_cfg(CFG_IN_DEB_LIMIT, 8'h00);
        no_idle = 1'b1;
        for (int n = 0; n < PULSE_TICKS; n++) begin
            in_one = ((n / 3) % 2) != 0;
            send_tick(tick_of({1'($urandom_range(1)), in_one, 3'b111}, 8'h00, 1'b0,
                              1'($urandom_range(1)), TO_SEL_NONE, 16'h0000));
        end
        send_tick(tick_of(5'h0F, 8'h00, 1'b1, 1'b0, TO_SEL_NONE, 16'h0000));
        repeat (12) send_tick(tick_of(5'h07, 8'h00, 1'b0, 1'b0, TO_SEL_NONE, 16'h0000));
        no_idle = 1'b0;
        drain_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        tick_if.valid = 1'b0;
        tick_if.payload = '0;
        result_if.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_extremes();
        test_default_random();
        test_inverted_levels_zero_limit();
        test_limit_lowered_mid_count();
        test_spare_index_and_no_idle();
        test_pulse_edges();
        if (error_count == 0 && predicted_status_q.size() == 0) begin
            $display("tick_scheduler_with_debounce test passed");
        end else begin
            if (predicted_status_q.size() != 0) begin
                $display("%0t: %0d expected results never arrived",
                         $time, predicted_status_q.size());
            end
            $display("tick_scheduler_with_debounce test failed");
        end
        $finish;
    end

    initial begin
        #32_000_000;
        $display("%0t: timeout", $time);
        $display("tick_scheduler_with_debounce test failed");
        $finish;
    end

endmodule

// File: tick_scheduler_with_debounce.f
design/tsd_pkg.sv
design/tsd_in_if.sv
design/tsd_out_if.sv
design/tick_scheduler_with_debounce.sv
tb/sv/tb_tick_scheduler_with_debounce.sv
